// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== design/ssc_pkg.sv =====
// Shared constants, types and helpers of the substring occurrence counter.
package ssc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int COOL_W      = $clog2(MAX_PATTERN);
  localparam int PAT_W       = MAX_PATTERN * BYTE_W;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = CFG_INDEX_W'(2);

  typedef struct packed {
    logic             advance;
    logic             restart;
    logic             hit_all;
    logic [LEN_W-1:0] len;
  } step_t;

  typedef struct packed {
    logic                   match_found;
    logic [COUNT_WIDTH-1:0] occurrence_total;
  } result_t;

  // Clamp the programmed length to 1..MAX_PATTERN.
  function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end
    return len;
  endfunction

endpackage

// ===== design/ssc_text_if.sv =====
// Input channel: one text byte per word.
interface ssc_text_if;
  import ssc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              restart;
  modport source (output valid, text_byte, restart, input ready);
  modport sink (input valid, text_byte, restart, output ready);
endinterface

// ===== design/ssc_result_if.sv =====
// Output channel: match flag and running total per word.
interface ssc_result_if;
  import ssc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   match_found;
  logic [COUNT_WIDTH-1:0] occurrence_total;
  modport source (output valid, match_found, occurrence_total, input ready);
  modport sink (input valid, match_found, occurrence_total, output ready);
endinterface

// ===== design/ssc_cfg_if.sv =====
// Configuration write channel: register index and data.
interface ssc_cfg_if;
  import ssc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/substring_occurrence_counter.sv =====
// Top level of the non-overlapping substring occurrence counter.
//
// Channels: text (sink) takes one text byte per word plus a restart flag;
// result (source) gives one word per text word: match_found and the
// running occurrence_total; cfg (sink, always ready) writes register 0
// (pattern bytes 0..7), 1 (pattern bytes 8..15) or 2 (pattern length).
// Writes to index 3 are dropped. Write cfg only while the block is idle.
//
// A row of 16 cells holds the byte window; each cell compares the byte
// entering it against its pattern byte in the same cycle. The result of
// an accepted text word is registered into the output register, or into
// the skid register while the output is stalled, and one word per cycle is
// sustained while the receiver takes results.
// A two-entry output buffer (output register plus skid register) keeps
// text.ready high for one more word after the receiver stalls; text.ready
// drops only once both entries hold results.
// Reset (rst, synchronous, active high) clears the window, fill count,
// cool-down, total and output buffer, and loads pattern length 1.
module substring_occurrence_counter (
  input logic          clk,
  input logic          rst,
  ssc_text_if.sink     text,
  ssc_result_if.source result,
  ssc_cfg_if.sink      cfg
);
  import ssc_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_length;
  logic [PAT_W-1:0]      pattern_vec;
  logic [LEN_W-1:0]      len;

  // Window chain.
  logic [BYTE_W-1:0] chain_in    [MAX_PATTERN];
  logic [BYTE_W-1:0] chain_out   [MAX_PATTERN];
  logic [BYTE_W-1:0] expect_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] used;
  logic [MAX_PATTERN-1:0] clear;

  // Output buffer.
  logic    in_fire;
  logic    out_open;
  logic    out_valid;
  logic    skid_valid;
  result_t out_word;
  result_t skid_word;
  step_t   step;
  result_t step_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LEN_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_LOW:  pattern_low    <= cfg.data;
        REG_PATTERN_HIGH: pattern_high   <= cfg.data;
        REG_PATTERN_LEN:  pattern_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_vec = {pattern_high, pattern_low};
  assign len         = used_length(pattern_length);

  // Cell j holds the byte that arrived j words ago; it must equal
  // pattern byte len-1-j for the occurrence to end at the newest byte.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LEN_W-1:0] pat_idx;

    if (j == 0) begin : g_head
      assign chain_in[j] = text.text_byte;
      assign clear[j]    = 1'b0;
    end else begin : g_body
      assign chain_in[j] = chain_out[j-1];
      assign clear[j]    = text.restart;
    end

    assign pat_idx        = len - LEN_W'(1) - LEN_W'(j);
    assign expect_byte[j] = pattern_vec[pat_idx[COOL_W-1:0]*BYTE_W +: BYTE_W];
    assign used[j]        = LEN_W'(j) < len;

    ssc_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (in_fire),
      .clear       (clear[j]),
      .used        (used[j]),
      .byte_in     (chain_in[j]),
      .expect_byte (expect_byte[j]),
      .byte_out    (chain_out[j]),
      .hit         (hit[j])
    );
  end

  assign step.advance = in_fire;
  assign step.restart = text.restart;
  assign step.hit_all = &hit;
  assign step.len     = len;

  ssc_track u_track (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .res  (step_res)
  );

  // Accept while the skid entry is free; the output entry drains first.
  assign text.ready = !skid_valid;
  assign in_fire    = text.valid && !skid_valid;
  assign out_open   = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_open) begin
        out_valid  <= skid_valid || in_fire;
        skid_valid <= 1'b0;
      end else begin
        skid_valid <= skid_valid || in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_open) begin
      out_word <= skid_valid ? skid_word : step_res;
    end else if (in_fire) begin
      skid_word <= step_res;
    end
  end

  assign result.valid            = out_valid;
  assign result.match_found      = out_word.match_found;
  assign result.occurrence_total = out_word.occurrence_total;

  // The skid entry is only filled behind a waiting output word.
  `ASSERT_NEVER(a_skid_behind_out, clk, rst, skid_valid && !out_valid, "skid holds word ahead of output")
  // A stalled output word is never dropped.
  `ASSERT_CLK(a_no_drop, clk, rst, out_valid && !result.ready |=> out_valid, "stalled result lost")
  // A counted occurrence always leaves a nonzero total.
  `ASSERT_NEVER(a_match_total, clk, rst, out_valid && out_word.match_found && out_word.occurrence_total == '0, "match with zero total")

endmodule

// ===== design/ssc_cell.sv =====
// One window cell: holds a byte, passes it on, compares the incoming byte.
module ssc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      clear,
  input  logic                      used,
  input  logic [ssc_pkg::BYTE_W-1:0] byte_in,
  input  logic [ssc_pkg::BYTE_W-1:0] expect_byte,
  output logic [ssc_pkg::BYTE_W-1:0] byte_out,
  output logic                      hit
);
  import ssc_pkg::*;

  logic [BYTE_W-1:0] stored;
  logic [BYTE_W-1:0] stored_next;

  // A cleared stream shifts zero into every cell but the newest.
  assign stored_next = clear ? '0 : byte_in;
  assign hit         = !used || (stored_next == expect_byte);
  assign byte_out    = stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
    end else if (advance) begin
      stored <= stored_next;
    end
  end

endmodule

// ===== design/ssc_track.sv =====
// Fill count, cool-down and saturating total.
module ssc_track (
  input  logic             clk,
  input  logic             rst,
  input  ssc_pkg::step_t   step,
  output ssc_pkg::result_t res
);
  import ssc_pkg::*;

  logic [LEN_W-1:0]       fill;
  logic [LEN_W-1:0]       fill_next;
  logic [COOL_W-1:0]      cooldown;
  logic [COOL_W-1:0]      cooldown_next;
  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [LEN_W-1:0]       fill_base;
  logic [COOL_W-1:0]      cool_base;
  logic [COUNT_WIDTH-1:0] total_base;
  logic                   match;

  always_comb begin
    fill_base  = step.restart ? '0 : fill;
    cool_base  = step.restart ? '0 : cooldown;
    total_base = step.restart ? '0 : total;
    fill_next  = (fill_base < LEN_W'(MAX_PATTERN)) ? fill_base + LEN_W'(1) : fill_base;
    cooldown_next = cool_base;
    total_next    = total_base;
    match         = 1'b0;
    if (cool_base != '0) begin
      cooldown_next = cool_base - COOL_W'(1);
    end else if ((fill_next >= step.len) && step.hit_all) begin
      match         = 1'b1;
      cooldown_next = COOL_W'(step.len - LEN_W'(1));
      // hold at the top value once saturated
      if (total_base != '1) begin
        total_next = total_base + COUNT_WIDTH'(1);
      end
    end
  end

  assign res.match_found      = match;
  assign res.occurrence_total = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      cooldown <= '0;
      total    <= '0;
    end else if (step.advance) begin
      fill     <= fill_next;
      cooldown <= cooldown_next;
      total    <= total_next;
    end
  end

endmodule

// ===== verif/substring_occurrence_counter_tb.sv =====
// Self-checking testbench of the substring occurrence counter: predicted match flags and totals
module substring_occurrence_counter_tb;
  import ssc_pkg::*;

  // Index 3 is not a register; writes to it must leave the pattern alone.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);

  localparam int GAP_MAX       = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 125;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT  = 30;
  localparam int TIMEOUT       = 1000000;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              restart;
  } text_word_t;

  logic clk;
  logic rst;

  ssc_text_if   text_ch ();
  ssc_result_if result_ch ();
  ssc_cfg_if    cfg_ch ();

  substring_occurrence_counter u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Shadow copy of the registers, updated at the write handshake.
  logic [CFG_DATA_W-1:0] pat_low_q  = '0;
  logic [CFG_DATA_W-1:0] pat_high_q = '0;
  logic [LEN_W-1:0]      pat_len_q  = LEN_W'(1);

  // Predicted scan state: byte window (entry 0 newest), fill, cool-down, total.
  logic [BYTE_W-1:0]      window_q [MAX_PATTERN] = '{default: '0};
  logic [LEN_W-1:0]       fill_q  = '0;
  logic [COOL_W-1:0]      cool_q  = '0;
  logic [COUNT_WIDTH-1:0] total_q = '0;

  text_word_t  pending_words [$];
  result_t     expected_results [$];

  int unsigned predicted_cnt = 0;
  int unsigned checked_cnt   = 0;
  int unsigned hit_cnt       = 0;
  int unsigned settings_cnt  = 0;
  int unsigned errors        = 0;

  bit          send_noisy = 1'b0;
  bit          recv_noisy = 1'b0;
  logic        hold_req;
  int unsigned hold_left = 0;
  int unsigned send_gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned recv_draw;
  text_word_t  next_word;
  result_t     prediction;
  result_t     oldest;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Map the programmed length onto 1..MAX_PATTERN.
  function automatic int effective_length(input logic [LEN_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_PATTERN) return MAX_PATTERN;
    return int'(raw);
  endfunction

  // Advance the predicted scan by one text byte and return the word it must produce.
  function automatic result_t scan_byte(input text_word_t w);
    logic [PAT_W-1:0] pat;
    int               len;
    logic             hit;
    result_t          r;
    pat = {pat_high_q, pat_low_q};
    len = effective_length(pat_len_q);
    if (w.restart) begin
      window_q = '{default: '0};
      fill_q   = '0;
      cool_q   = '0;
      total_q  = '0;
    end
    for (int i = MAX_PATTERN - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = w.value;
    if (fill_q < MAX_PATTERN) fill_q = fill_q + 1'b1;
    hit = 1'b0;
    // A running cool-down blocks any match until it has counted out.
    if (cool_q != '0) begin
      cool_q = cool_q - 1'b1;
    end else if (fill_q >= len) begin
      hit = 1'b1;
      // Oldest byte of the last len bytes lines up with pattern byte 0.
      for (int k = 0; k < len; k++) begin
        if (window_q[len-1-k] != pat[BYTE_W*k +: BYTE_W]) hit = 1'b0;
      end
      if (hit) begin
        cool_q = COOL_W'(len - 1);
        if (total_q != '1) total_q = total_q + 1'b1;
      end
    end
    r.match_found      = hit;
    r.occurrence_total = total_q;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("mismatch at result word %0d: %s", checked_cnt, msg);
    end
  endtask

  // Drive one register write and wait for its handshake; valid stays high for the caller.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PATTERN_LOW:  pat_low_q = val;
      REG_PATTERN_HIGH: pat_high_q = val;
      REG_PATTERN_LEN:  pat_len_q = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Load a full pattern and length; sometimes slip in a write to the unused index.
  task automatic program_pattern(input logic [PAT_W-1:0] pat,
                                 input logic [CFG_DATA_W-1:0] len_word);
    write_reg(REG_PATTERN_LOW, pat[CFG_DATA_W-1:0]);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(REG_PATTERN_HIGH, pat[PAT_W-1:CFG_DATA_W]);
    write_reg(REG_PATTERN_LEN, len_word);
    cfg_ch.valid <= 1'b0;
    settings_cnt++;
    @(posedge clk);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] v, input logic rs);
    text_word_t w;
    w.value   = v;
    w.restart = rs;
    pending_words.push_back(w);
  endtask

  // Hold until every queued byte has gone in and every predicted word has come out.
  // Look at the falling edge, once the rising edge's updates have all landed.
  task automatic wait_drained;
    do @(negedge clk);
    while (pending_words.size() != 0 || text_ch.valid || checked_cnt != predicted_cnt);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: present queued bytes, predict each one at its handshake, then
  // idle for the gap drawn when the byte was put up.
  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
      send_gap_left <= 0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (text_ch.valid) begin
        prediction = scan_byte(text_word_t'{value: text_ch.text_byte,
                                            restart: text_ch.restart});
        expected_results.push_back(prediction);
        predicted_cnt <= predicted_cnt + 1;
        if (prediction.match_found) hit_cnt++;
      end
      if (send_gap_left != 0) begin
        send_gap_left <= send_gap_left - 1;
        text_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        text_ch.text_byte <= next_word.value;
        text_ch.restart   <= next_word.restart;
        text_ch.valid     <= 1'b1;
        send_gap_left     <= send_noisy ? $urandom_range(0, GAP_MAX) : 0;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: after each taken word, drop ready for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
    end else if (result_ch.ready) begin
      if (result_ch.valid) begin
        recv_draw = recv_noisy ? $urandom_range(0, GAP_MAX) : 0;
        if (recv_draw != 0) begin
          result_ch.ready <= 1'b0;
          stall_left      <= recv_draw;
        end
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor: compare each taken word with the oldest prediction made before this edge.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (checked_cnt == predicted_cnt) begin
        report_mismatch($sformatf("word with no byte behind it (match %0b, total %0d)",
                                  result_ch.match_found, result_ch.occurrence_total));
      end else begin
        oldest = expected_results.pop_front();
        checked_cnt <= checked_cnt + 1;
        if (result_ch.match_found !== oldest.match_found) begin
          report_mismatch($sformatf("match_found %b, predicted %b",
                                    result_ch.match_found, oldest.match_found));
        end
        if (result_ch.occurrence_total !== oldest.occurrence_total) begin
          report_mismatch($sformatf("occurrence_total %0d, predicted %0d",
                                    result_ch.occurrence_total, oldest.occurrence_total));
        end
      end
    end
  end

  initial begin
    logic [PAT_W-1:0]      pat;
    logic [CFG_DATA_W-1:0] len_word;
    logic [BYTE_W-1:0]     sym [3];
    int                    eff;
    int                    count;
    int                    pick;
    int                    run;
    int                    base;
    bit                    alpha;

    rst               = 1'b1;
    hold_req          = 1'b0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.restart   = 1'b0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_PATTERN_LOW;
    cfg_ch.data       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset pattern: a single zero byte, so every zero byte counts.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    wait_drained();

    // Self-overlapping pattern "aaa": six a's give two counts and leave a cool-down running.
    program_pattern(PAT_W'(24'h616161), CFG_DATA_W'(3));
    repeat (6) queue_byte(8'h61, 1'b0);
    wait_drained();

    // Length zero acts as one; the running cool-down has to finish first.
    program_pattern({pat_high_q, pat_low_q}, CFG_DATA_W'(0));
    repeat (3) queue_byte(8'h61, 1'b0);
    wait_drained();

    // All-ones pattern with an oversized length, which acts as the full sixteen.
    program_pattern('1, CFG_DATA_W'(17));
    queue_byte(8'hFF, 1'b1);
    repeat (15) queue_byte(8'hFF, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // The pressure phase keeps both sides busy so the hold-off backs the block up.
      send_noisy = (ph != 2) && ($urandom_range(0, 2) != 0);
      recv_noisy = (ph != 2) && ($urandom_range(0, 2) != 0);
      foreach (sym[s]) sym[s] = BYTE_W'($urandom);
      alpha = (ph < 2) || ($urandom_range(0, 3) != 0);
      // Draw pattern bytes from a tiny alphabet most of the time so repeats and overlaps occur.
      for (int k = 0; k < MAX_PATTERN; k++) begin
        pat[BYTE_W*k +: BYTE_W] = alpha ? sym[$urandom_range(0, 1)] : BYTE_W'($urandom);
      end
      pick = $urandom_range(0, 7);
      if (ph == 0) begin
        len_word = CFG_DATA_W'(1);
      end else if (ph == 1) begin
        len_word = CFG_DATA_W'(MAX_PATTERN);
      end else if (pick == 0) begin
        len_word = CFG_DATA_W'(MAX_PATTERN);
      end else if (pick == 1) begin
        len_word = '0;
      end else if (pick == 2) begin
        len_word = CFG_DATA_W'($urandom_range(MAX_PATTERN + 1, 31));
      end else if (pick == 3) begin
        // Junk in the upper data bits must be ignored.
        len_word = {$urandom, $urandom};
      end else begin
        len_word = CFG_DATA_W'($urandom_range(1, 5));
      end
      program_pattern(pat, len_word);
      eff = effective_length(pat_len_q);

      base  = predicted_cnt;
      count = 0;
      while (count < PHASE_WORDS) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // Whole copy of the pattern.
          for (int j = 0; j < eff; j++) begin
            queue_byte(pat[BYTE_W*j +: BYTE_W], $urandom_range(0, 79) == 0);
          end
          count += eff;
        end else if (pick < 7) begin
          // Prefix of the pattern, at times the whole of it.
          run = $urandom_range(1, eff);
          for (int j = 0; j < run; j++) begin
            queue_byte(pat[BYTE_W*j +: BYTE_W], $urandom_range(0, 79) == 0);
          end
          count += run;
        end else begin
          // Noise, mostly from the alphabet, sometimes any byte.
          run = $urandom_range(1, 4);
          for (int j = 0; j < run; j++) begin
            queue_byte(($urandom_range(0, 3) == 0) ? BYTE_W'($urandom)
                                                   : sym[$urandom_range(0, 2)],
                       $urandom_range(0, 79) == 0);
          end
          count += run;
        end
      end

      if (ph == 2) begin
        // Let traffic get going, then hold the receiver off while the sender keeps offering.
        while (predicted_cnt < base + 20) @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d text words over %0d pattern settings, %0d counted occurrences",
             predicted_cnt, settings_cnt, hit_cnt);
    $display("included a %0d-cycle receiver hold-off; %0d mismatches seen",
             HOLD_CYCLES, errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[substring_occurrence_counter] OK");
    end else begin
      $display("[substring_occurrence_counter] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("timeout: %0d of %0d predicted words checked", checked_cnt, predicted_cnt);
    $display("[substring_occurrence_counter] ERROR");
    $finish;
  end

endmodule
